@@ rtl/isaac_random_generator_macros.svh @@
// assertion macros for the isaac random generator
`ifndef ISAAC_RANDOM_GENERATOR_MACROS_SVH
`define ISAAC_RANDOM_GENERATOR_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define ISAAC_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked on clk outside reset
`define ISAAC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/isaac_pkg.sv @@
// shared constants, types and codes of the isaac random generator
`timescale 1ns / 1ps
package isaac_pkg;
  localparam int SIZE_LOG2   = 8;
  localparam int TBL_SIZE    = 1 << SIZE_LOG2;
  localparam int HALF_SIZE   = TBL_SIZE / 2;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [31:0] GOLDEN = 32'h9e3779b9;

  typedef logic [SIZE_LOG2-1:0] idx_t;
  typedef logic [SIZE_LOG2:0]   cnt_t;

  typedef enum logic [1:0] {
    FN_D16  = 2'd0,
    FN_D32  = 2'd1,
    FN_D64  = 2'd2,
    FN_SEED = 2'd3
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] seed;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_out_t;
endpackage

@@ rtl/isaac_if.sv @@
// request and response channel interfaces
`timescale 1ns / 1ps
interface isaac_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] seed_word;
  modport source (output valid, func, seed_word, input ready);
  modport sink (input valid, func, seed_word, output ready);
endinterface

interface isaac_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

@@ rtl/isaac_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module isaac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/isaac_front.sv @@
// front end: accepts request items and queues them for the core
`timescale 1ns / 1ps
module isaac_front (
  input  logic             clk,
  input  logic             rst,
  isaac_req_if.sink        req,
  output isaac_pkg::q_out_t q,
  input  logic             pop
);
  import isaac_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  op_t                          slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]             wptr;
  logic [PTR_W-1:0]             rptr;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] count;
  logic                         push;
  logic                         take;

  assign req.ready = (count != QUEUE_DEPTH[$clog2(QUEUE_DEPTH+1)-1:0]);
  assign push      = req.valid && req.ready;
  assign take      = pop && (count != '0);
  assign q.valid   = (count != '0);
  assign q.op      = slots[rptr];

  // queue storage, classified request kind
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr].func <= func_t'(req.func);
      slots[wptr].seed <= req.seed_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (take) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

@@ rtl/isaac_core.sv @@
// back end: seeding, refill passes and draws over the two table rams
`timescale 1ns / 1ps
`include "isaac_random_generator_macros.svh"
module isaac_core (
  input  logic              clk,
  input  logic              rst,
  input  isaac_pkg::q_out_t q,
  output logic              pop,
  isaac_rsp_if.source       rsp
);
  import isaac_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_WAIT, S_ADD1, S_SCR, S_WR, S_RD2,
    S_R0, S_R1, S_R2, S_R3, S_R4, S_R5
  } state_t;

  typedef enum logic [1:0] {PH_INIT, PH_P1, PH_P2} phase_t;

  state_t      state;
  phase_t      phase;
  func_t       func;
  logic [31:0] seed;
  logic        seeding;
  logic        respond;
  logic        first;
  logic [31:0] hi;
  logic [31:0] v [8];
  logic [31:0] v_next [8];
  logic [2:0]  row;
  logic [1:0]  scr_cnt;
  logic [3:0]  k;
  idx_t        base;
  idx_t        i;
  logic [31:0] acc_a;
  logic [31:0] acc_b;
  logic [31:0] pc;
  logic [31:0] x;
  logic [31:0] y;
  cnt_t        wl;
  cnt_t        wl_m1;
  logic        out_valid;
  logic [63:0] out_value;

  logic        mem_we;
  idx_t        mem_waddr;
  logic [31:0] mem_wdata;
  idx_t        mem_raddr;
  logic [31:0] mem_rdata;
  logic        res_we;
  idx_t        res_raddr;
  logic [31:0] res_rdata;
  logic [31:0] sh;
  logic [31:0] a_new;
  logic [31:0] y_new;
  logic [31:0] t;
  logic [31:0] rs;
  logic [2:0]  r1;
  logic [2:0]  r2;
  logic [2:0]  r3;
  logic [2:0]  km1;

  localparam idx_t LAST_BLK = idx_t'(TBL_SIZE - 8);
  localparam idx_t LAST_IDX = idx_t'(TBL_SIZE - 1);
  localparam idx_t HALF_IDX = idx_t'(HALF_SIZE);
  localparam cnt_t FULL_CNT = cnt_t'(TBL_SIZE);

  isaac_ram #(.WIDTH(32), .DEPTH(TBL_SIZE)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  isaac_ram #(.WIDTH(32), .DEPTH(TBL_SIZE)) u_res (
    .clk   (clk),
    .we    (res_we),
    .waddr (i),
    .wdata (mem_rdata + x),
    .raddr (res_raddr),
    .rdata (res_rdata)
  );

  assign rsp.valid = out_valid;
  assign rsp.value = out_value;
  assign pop       = (state == S_IDLE) && q.valid && !out_valid;
  assign wl_m1     = wl - 1'b1;
  assign km1       = 3'(k - 4'd1);

  // one row of the golden-ratio mix
  always_comb begin
    r1 = row + 3'd1;
    r2 = row + 3'd2;
    r3 = row + 3'd3;
    case (row)
      3'd0:    rs = v[r1] << 11;
      3'd1:    rs = v[r1] >> 2;
      3'd2:    rs = v[r1] << 8;
      3'd3:    rs = v[r1] >> 16;
      3'd4:    rs = v[r1] << 10;
      3'd5:    rs = v[r1] >> 4;
      3'd6:    rs = v[r1] << 8;
      default: rs = v[r1] >> 9;
    endcase
    t = v[row] ^ rs;
    v_next = v;
    v_next[row] = t;
    v_next[r3]  = v[r3] + t;
    v_next[r1]  = v[r1] + v[r2];
  end

  // refill step arithmetic
  always_comb begin
    case (i[1:0])
      2'd0:    sh = acc_a << 13;
      2'd1:    sh = acc_a >> 6;
      2'd2:    sh = acc_a << 2;
      default: sh = acc_a >> 16;
    endcase
    a_new = (acc_a ^ sh) + mem_rdata;
    y_new = mem_rdata + acc_a + acc_b;
  end

  // ram address and write selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = i;
    mem_wdata = y_new;
    mem_raddr = i;
    res_we    = 1'b0;
    res_raddr = wl_m1[SIZE_LOG2-1:0];
    case (state)
      S_WR: begin
        mem_we    = 1'b1;
        mem_waddr = base | idx_t'(k[2:0]);
        mem_wdata = v[k[2:0]];
      end
      S_RD2:   mem_raddr = base | idx_t'(k[2:0]);
      S_R1:    mem_raddr = i + HALF_IDX;
      S_R2:    mem_raddr = x[2 +: SIZE_LOG2];
      S_R3:    mem_we    = 1'b1;
      S_R4:    mem_raddr = y[SIZE_LOG2+2 +: SIZE_LOG2];
      S_R5:    res_we    = 1'b1;
      default: mem_raddr = i;
    endcase
  end

  // control sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SCR;
      phase     <= PH_INIT;
      seeding   <= 1'b1;
      respond   <= 1'b0;
      seed      <= '0;
      row       <= '0;
      scr_cnt   <= '0;
      wl        <= '0;
      out_valid <= 1'b0;
      for (int n = 0; n < 8; n++) v[n] <= GOLDEN;
    end else begin
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            func  <= q.op.func;
            first <= 1'b1;
            if (q.op.func == FN_SEED) begin
              seed    <= q.op.seed;
              seeding <= 1'b1;
              respond <= 1'b1;
              phase   <= PH_INIT;
              row     <= '0;
              scr_cnt <= '0;
              for (int n = 0; n < 8; n++) v[n] <= GOLDEN;
              state   <= S_SCR;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          if (wl == '0) begin
            pc    <= pc + 32'd1;
            acc_b <= acc_b + pc + 32'd1;
            i     <= '0;
            state <= S_R0;
          end else begin
            wl    <= wl_m1;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (func == FN_D64 && first) begin
            hi    <= res_rdata;
            first <= 1'b0;
            state <= S_FETCH;
          end else begin
            case (func)
              FN_D16:  out_value <= {48'd0, res_rdata[15:0]};
              FN_D32:  out_value <= {32'd0, res_rdata};
              default: out_value <= {hi, res_rdata};
            endcase
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_ADD1: begin
          for (int n = 0; n < 8; n++) v[n] <= v[n] + seed;
          row   <= '0;
          state <= S_SCR;
        end
        S_SCR: begin
          v   <= v_next;
          row <= row + 3'd1;
          if (row == 3'd7) begin
            if (phase == PH_INIT) begin
              scr_cnt <= scr_cnt + 2'd1;
              if (scr_cnt == 2'd3) begin
                phase <= PH_P1;
                base  <= '0;
                state <= S_ADD1;
              end
            end else begin
              k     <= '0;
              state <= S_WR;
            end
          end
        end
        S_WR: begin
          if (k == 4'd7) begin
            k <= '0;
            if (base == LAST_BLK) begin
              base <= '0;
              if (phase == PH_P1) begin
                phase <= PH_P2;
                state <= S_RD2;
              end else begin
                acc_a <= '0;
                acc_b <= 32'd1;
                pc    <= 32'd1;
                i     <= '0;
                state <= S_R0;
              end
            end else begin
              base  <= base + idx_t'(8);
              state <= (phase == PH_P1) ? S_ADD1 : S_RD2;
            end
          end else begin
            k <= k + 4'd1;
          end
        end
        S_RD2: begin
          if (k != 4'd0) begin
            v[km1] <= v[km1] + mem_rdata;
          end
          k <= k + 4'd1;
          if (k == 4'd8) begin
            row   <= '0;
            state <= S_SCR;
          end
        end
        S_R0: state <= S_R1;
        S_R1: begin
          x     <= mem_rdata;
          state <= S_R2;
        end
        S_R2: begin
          acc_a <= a_new;
          state <= S_R3;
        end
        S_R3: begin
          y     <= y_new;
          state <= S_R4;
        end
        S_R4: state <= S_R5;
        S_R5: begin
          acc_b <= mem_rdata + x;
          i     <= i + 1'b1;
          if (i == LAST_IDX) begin
            wl <= FULL_CNT;
            if (seeding) begin
              seeding <= 1'b0;
              if (respond) begin
                out_value <= '0;
                out_valid <= 1'b1;
              end
              state <= S_IDLE;
            end else begin
              state <= S_FETCH;
            end
          end else begin
            state <= S_R0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ISAAC_ASSERT_NOW(a_wl_range, 1'b1, wl <= FULL_CNT, "words left above table size")
  `ISAAC_ASSERT_NEXT(a_refill_full, state == S_R5 && i == LAST_IDX, wl == FULL_CNT, "refill did not fill table")
  `ISAAC_ASSERT_NOW(a_pop_out_free, pop, !out_valid && q.valid, "item taken while output busy")
endmodule

@@ rtl/isaac_random_generator.sv @@
// top level of the isaac random generator
// from the queue head a 16, 32 or 64-bit draw is served from a full table, after
// a refill pass (states R0 to R5 for each entry) whenever the table runs empty;
// one item at a time, the next waits for the result handshake
// a reseed mixes rows one per cycle, then does table ram port bound writes and
// reads, then one refill pass
// after rst the core runs the reseed with zero before draws
`timescale 1ns / 1ps
module isaac_random_generator (
  input logic         clk,
  input logic         rst,
  isaac_req_if.sink   req,
  isaac_rsp_if.source rsp
);
  import isaac_pkg::*;

  q_out_t q;
  logic   pop;

  isaac_front u_front (
    .clk (clk),
    .rst (rst),
    .req (req),
    .q   (q),
    .pop (pop)
  );

  isaac_core u_core (
    .clk (clk),
    .rst (rst),
    .q   (q),
    .pop (pop),
    .rsp (rsp)
  );
endmodule
